[src/cdt_pkg.sv]
// Package: types, codes and sizes shared by the conditional directive tracker.
`timescale 1ns / 1ps
package cdt_pkg;

  localparam int unsigned MAX_LEVELS = 32;
  localparam int unsigned LVL_W      = $clog2(MAX_LEVELS);
  localparam int unsigned DEPTH_W    = 5;
  localparam int unsigned IN_DATA_W  = 8;
  localparam int unsigned IN_USER_W  = 3;
  localparam int unsigned OUT_DATA_W = 16;

  typedef enum logic [2:0] {
    ACT_IF     = 3'd0,
    ACT_IFDEF  = 3'd1,
    ACT_IFNDEF = 3'd2,
    ACT_ELSE   = 3'd3,
    ACT_ELIF   = 3'd4,
    ACT_ENDIF  = 3'd5
  } action_e;

  typedef enum logic [1:0] {
    ARG_PRESENT     = 2'd0,
    ARG_MISSING     = 2'd1,
    ARG_FORM        = 2'd2,
    ARG_MISSING_ALT = 2'd3
  } arg_e;

  typedef enum logic [2:0] {
    ERR_NONE = 3'd0,
    ERR_DEEP = 3'd1,
    ERR_NOIF = 3'd2,
    ERR_ELSE = 3'd3,
    ERR_ARG  = 3'd4,
    ERR_FORM = 3'd5
  } err_e;

  typedef struct packed {
    logic had_else;
    logic taken;
    logic was_incl;
  } level_flags_t;

  typedef struct packed {
    arg_e    arg;
    logic    cond;
    action_e action;
  } item_t;

  typedef struct packed {
    logic [DEPTH_W-1:0] depth;
    err_e               err;
    logic               incl;
  } result_t;

endpackage

[src/cdt_in_reg.sv]
// Input register stage: captures one directive item from the slave channel.
`timescale 1ns / 1ps
module cdt_in_reg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  cdt_pkg::item_t item_i,
  input  logic          pop_i,
  output logic          valid_o,
  output cdt_pkg::item_t item_o
);
  import cdt_pkg::*;

  logic  valid_q;
  item_t item_q;

  assign ready_o = !valid_q || pop_i;
  assign valid_o = valid_q;
  assign item_o  = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      item_q <= item_i;
    end
  end

endmodule

[src/cdt_core.sv]
// Directive evaluation: include flag, level count and per-level flag stack.
`timescale 1ns / 1ps
module cdt_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_i,
  input  cdt_pkg::item_t  item_i,
  output cdt_pkg::result_t result_o
);
  import cdt_pkg::*;

  localparam logic [LVL_W-1:0] TOP_LEVEL = LVL_W'(MAX_LEVELS - 1);

  logic             incl_q, incl_d;
  logic [LVL_W-1:0] cnt_q, cnt_d;
  level_flags_t     stack_q [MAX_LEVELS];

  level_flags_t     f;
  level_flags_t     wr_data;
  logic             wr_en;
  logic [LVL_W-1:0] wr_addr;
  err_e             err;
  logic             want;
  logic             is_if;
  logic             eval;

  assign f = stack_q[cnt_q];

  always_comb begin
    incl_d  = incl_q;
    cnt_d   = cnt_q;
    wr_en   = 1'b0;
    wr_addr = cnt_q;
    wr_data = f;
    err     = ERR_NONE;
    eval    = 1'b0;
    is_if   = 1'b1;
    want    = 1'b1;
    case (item_i.action)
      ACT_IF, ACT_IFDEF, ACT_IFNDEF: begin
        if (cnt_q == TOP_LEVEL) begin
          err = ERR_DEEP;
        end else begin
          cnt_d   = cnt_q + 1'b1;
          wr_en   = 1'b1;
          wr_addr = cnt_q + 1'b1;
          wr_data = '0;
          if (incl_q) begin
            wr_data.was_incl = 1'b1;
            eval  = 1'b1;
            is_if = (item_i.action == ACT_IF);
            want  = (item_i.action != ACT_IFNDEF);
          end
        end
      end
      ACT_ELSE: begin
        if (cnt_q == '0) begin
          err = ERR_NOIF;
        end else if (f.had_else) begin
          err = ERR_ELSE;
        end else begin
          wr_en = 1'b1;
          wr_data.had_else = 1'b1;
          if (f.was_incl) begin
            incl_d = !(incl_q || f.taken);
          end
        end
      end
      ACT_ELIF: begin
        if (cnt_q == '0) begin
          err = ERR_NOIF;
        end else if (f.had_else) begin
          err = ERR_ELSE;
        end else if (!f.was_incl || f.taken) begin
          incl_d = 1'b0;
        end else begin
          wr_en = 1'b1;
          eval  = 1'b1;
        end
      end
      ACT_ENDIF: begin
        if (cnt_q == '0) begin
          err = ERR_NOIF;
        end else begin
          incl_d = f.was_incl;
          cnt_d  = cnt_q - 1'b1;
        end
      end
      default: begin
      end
    endcase

    if (eval) begin
      if (item_i.arg == ARG_MISSING || item_i.arg == ARG_MISSING_ALT) begin
        err = ERR_ARG;
      end else if (item_i.arg == ARG_FORM) begin
        err = is_if ? ERR_FORM : ERR_ARG;
      end else if (item_i.cond == want) begin
        incl_d = 1'b1;
        wr_data.taken = 1'b1;
      end else begin
        incl_d = 1'b0;
      end
    end
  end

  assign result_o.incl  = incl_d;
  assign result_o.err   = err;
  assign result_o.depth = DEPTH_W'(cnt_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      incl_q <= 1'b1;
      cnt_q  <= '0;
    end else if (step_i) begin
      incl_q <= incl_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i && wr_en) begin
      stack_q[wr_addr] <= wr_data;
    end
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= TOP_LEVEL)
    else $error("level count out of range");

  a_err_keeps_incl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && err != ERR_NONE |=> $stable(incl_q))
    else $error("erroneous directive changed include flag");

  a_endif_pops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && item_i.action == ACT_ENDIF && cnt_q != '0
    |=> cnt_q == LVL_W'($past(cnt_q) - 1'b1))
    else $error("endif did not pop one level");

  a_deep_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && err == ERR_DEEP |-> cnt_q == TOP_LEVEL)
    else $error("too-deep error below full stack");

endmodule

[src/cdt_out_reg.sv]
// Result register stage: holds one result item for the master channel.
`timescale 1ns / 1ps
module cdt_out_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  cdt_pkg::result_t result_i,
  output logic             free_o,
  output logic             valid_o,
  input  logic             ready_i,
  output cdt_pkg::result_t result_o
);
  import cdt_pkg::*;

  logic    valid_q;
  result_t result_q;

  assign free_o   = !valid_q || ready_i;
  assign valid_o  = valid_q;
  assign result_o = result_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

endmodule

[src/conditional_directive_tracker_top.sv]
// Conditional directive tracker: nesting of if/ifdef/ifndef/else/elif/endif.
// Usage:
//   Slave stream carries one directive per item: tuser holds the directive
//   kind, tdata its evaluated condition and argument status. Master stream
//   returns exactly one result per directive: include flag, error code and
//   nesting depth after the directive.
//   A slave item is registered in the input register, then evaluated, and its
//   result is registered in the result register, which drives master tvalid;
//   evaluation waits while the result register is full and not taken.
//   Throughput is 1 item per cycle unless the master side stalls: each
//   directive touches only the top level stack entry and the include flag.
//   Reset clears the include flag to 1 and the level count to 0; the stack
//   entries are written by the push that opens each level.
//   When the master side stalls, the result register holds its item and the
//   input register takes one more; s_axis_tready drops once both are full.
`timescale 1ns / 1ps
module conditional_directive_tracker_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // [0] condition, [2:1] arg_status, [7:3] zero
  input  logic [cdt_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,
  // [2:0] action
  input  logic [cdt_pkg::IN_USER_W-1:0]  s_axis_tuser_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // [0] include_lines, [3:1] error_code, [8:4] nest_depth, [15:9] zero
  output logic [cdt_pkg::OUT_DATA_W-1:0] m_axis_tdata_o
);
  import cdt_pkg::*;

  item_t   in_item;
  item_t   cur_item;
  logic    cur_valid;
  logic    out_free;
  logic    step;
  result_t core_result;
  result_t out_result;

  assign in_item.action = action_e'(s_axis_tuser_i[2:0]);
  assign in_item.cond   = s_axis_tdata_i[0];
  assign in_item.arg    = arg_e'(s_axis_tdata_i[2:1]);

  assign step = cur_valid && out_free;

  cdt_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid_i),
    .ready_o (s_axis_tready_o),
    .item_i  (in_item),
    .pop_i   (step),
    .valid_o (cur_valid),
    .item_o  (cur_item)
  );

  cdt_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (cur_item),
    .result_o (core_result)
  );

  cdt_out_reg u_out_reg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (step),
    .result_i (core_result),
    .free_o   (out_free),
    .valid_o  (m_axis_tvalid_o),
    .ready_i  (m_axis_tready_i),
    .result_o (out_result)
  );

  assign m_axis_tdata_o = OUT_DATA_W'(out_result);

endmodule
